// ===== design/assert_macros.svh =====
// Assertion macros used by the checker.
// Each macro expects signals named clk and rst_n in the enclosing scope.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// A property that must hold at every clock edge outside reset.
`define ASSERT_CLK(label, prop, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (prop)) else $error(msg);

// An implication checked at every clock edge outside reset.
`define ASSERT_IMPLY(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// A next-cycle implication checked at every clock edge outside reset.
`define ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

// ===== design/ifd_pkg.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder package
// Shared constants, the frame record type and the byte-wide CRC-16 update.
// ----------------------------------------------------------------------------
package ifd_pkg;

  // Largest payload accepted before a frame is dropped.
  localparam int MAX_PAYLOAD = 256;
  localparam int OFS_W       = $clog2(MAX_PAYLOAD + 1);
  localparam int LEN_CMP_W   = 17;

  // Payload bytes kept for item extraction.
  localparam int STORE_DEPTH = 32;
  localparam int STORE_AW    = $clog2(STORE_DEPTH);
  localparam int REC_BYTES   = 30;

  localparam logic [7:0]  SYNC1_BYTE = 8'h5A;
  localparam logic [7:0]  SYNC2_BYTE = 8'hA5;
  localparam logic [15:0] CRC_POLY   = 16'h1021;

  // Item tags.
  localparam int NUM_TAGS = 5;
  localparam int TAG_IW   = $clog2(NUM_TAGS);
  localparam logic [NUM_TAGS-1:0][7:0] TAG_RESET = {8'd208, 8'd192, 8'd176, 8'd160, 8'd144};
  localparam int TAG_OFS [NUM_TAGS] = '{0, 2, 9, 16, 23};

  // Configuration register indexes.
  localparam logic [2:0] REG_ID_TAG     = 3'd0;
  localparam logic [2:0] REG_ACCEL_TAG  = 3'd1;
  localparam logic [2:0] REG_GYRO_TAG   = 3'd2;
  localparam logic [2:0] REG_MAGNET_TAG = 3'd3;
  localparam logic [2:0] REG_EULER_TAG  = 3'd4;

  // Result kinds.
  localparam logic [2:0] KIND_ID     = 3'd0;
  localparam logic [2:0] KIND_ACCEL  = 3'd1;
  localparam logic [2:0] KIND_GYRO   = 3'd2;
  localparam logic [2:0] KIND_MAGNET = 3'd3;
  localparam logic [2:0] KIND_EULER  = 3'd4;
  localparam logic [2:0] KIND_STATUS = 3'd5;

  typedef struct packed {
    logic       valid;
    logic [2:0] index;
    logic [7:0] data;
  } ifd_cfg_wr_t;

  // Everything the back end needs to emit the results of one frame.
  typedef struct packed {
    logic                      ok;
    logic [15:0]               len;
    logic [NUM_TAGS-1:0]       mask;
    logic [REC_BYTES-1:0][7:0] bytes;
  } ifd_rec_t;

  localparam int Q_DEPTH = 2;
  localparam int Q_AW    = $clog2(Q_DEPTH);

  // CRC-16-CCITT, MSB first, one byte.
  function automatic logic [15:0] crc_byte(input logic [15:0] crc, input logic [7:0] b);
    logic [15:0] c;
    c = crc ^ {b, 8'h00};
    for (int i = 0; i < 8; i++) begin
      c = c[15] ? ({c[14:0], 1'b0} ^ CRC_POLY) : {c[14:0], 1'b0};
    end
    return c;
  endfunction

  localparam logic [15:0] CRC_SYNC_INIT = crc_byte(crc_byte(16'h0000, SYNC1_BYTE), SYNC2_BYTE);

endpackage

// ===== design/imu_frame_decoder.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder
// Byte-serial parser for sync/length/CRC16 framed sensor packets.
// ----------------------------------------------------------------------------
//
// Channel   Direction  Word contents
// in_       slave      one received serial byte
// out_      master     one decoded item: kind, three values, last of frame
// cfg_      slave      write of one item tag register (index 0..4)
//
// The decoder takes one byte per cycle whenever in_tready is high. The front
// end parses and updates the CRC-16 with a byte-wide step in the same cycle,
// so a frame end is known on the cycle its last byte is accepted. It then
// pushes a frame record into a two-entry queue; the back end emits one word
// per cycle from it while out_tready does not stall it, up to six words per
// frame, each passing through the back end's output register. in_tready drops
// only when both queue slots hold frames, which happens only under sustained
// backpressure on the output. Reset is synchronous; the field store is
// cleared directly by it, so no clearing pass follows. cfg_ready is always
// high; tag registers are meant to be written while the decoder is idle.
//
module imu_frame_decoder (
  input  logic        clk,
  input  logic        rst_n,
  // Input bytes.
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] rx_byte
  // Decoded items.
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [47:0] out_tdata,  // [15:0] value_a, [31:16] value_b, [47:32] value_c
  output logic [2:0]  out_tuser,  // [2:0] item_kind
  output logic        out_tlast,  // last_of_frame
  // Tag register writes.
  input  logic        cfg_valid,
  output logic        cfg_ready,
  input  logic [2:0]  cfg_index,
  input  logic [7:0]  cfg_data
);
  import ifd_pkg::*;

  ifd_cfg_wr_t cfg_wr;
  ifd_rec_t    push_rec;
  ifd_rec_t    head_rec;
  logic        push;
  logic        q_full;
  logic        q_nonempty;
  logic        q_pop;
  logic        byte_acc;

  // A byte is taken whenever the queue has room for the frame it might end.
  assign in_tready = !q_full;
  assign byte_acc  = in_tvalid && in_tready;

  assign cfg_ready    = 1'b1;
  assign cfg_wr.valid = cfg_valid && cfg_ready;
  assign cfg_wr.index = cfg_index;
  assign cfg_wr.data  = cfg_data;

  ifd_front u_front (
    .clk      (clk),
    .rst_n    (rst_n),
    .byte_acc (byte_acc),
    .rx_byte  (in_tdata),
    .cfg_wr   (cfg_wr),
    .push     (push),
    .push_rec (push_rec)
  );

  ifd_queue u_queue (
    .clk      (clk),
    .rst_n    (rst_n),
    .push     (push),
    .push_rec (push_rec),
    .full     (q_full),
    .pop      (q_pop),
    .nonempty (q_nonempty),
    .head_rec (head_rec)
  );

  ifd_back u_back (
    .clk       (clk),
    .rst_n     (rst_n),
    .rec_valid (q_nonempty),
    .rec       (head_rec),
    .rec_pop   (q_pop),
    .out_valid (out_tvalid),
    .out_ready (out_tready),
    .out_kind  (out_tuser),
    .out_data  (out_tdata),
    .out_last  (out_tlast)
  );

endmodule

// ===== design/ifd_front.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder front end
// Parses bytes, runs the CRC, fills the field store and tag registers, and
// hands one record per completed frame to the queue.
// ----------------------------------------------------------------------------
module ifd_front (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                byte_acc,
  input  logic [7:0]          rx_byte,
  input  ifd_pkg::ifd_cfg_wr_t cfg_wr,
  output logic                push,
  output ifd_pkg::ifd_rec_t   push_rec
);
  import ifd_pkg::*;

  typedef enum logic [6:0] {
    ST_IDLE  = 7'b0000001,
    ST_SYNC2 = 7'b0000010,
    ST_LENL  = 7'b0000100,
    ST_LENH  = 7'b0001000,
    ST_CRCL  = 7'b0010000,
    ST_CRCH  = 7'b0100000,
    ST_DATA  = 7'b1000000
  } ifd_state_t;

  ifd_state_t                 state_r, state_nxt;
  logic [15:0]                len_r, len_nxt;
  logic [15:0]                rcrc_r, rcrc_nxt;
  logic [15:0]                crc_r, crc_nxt;
  logic [OFS_W-1:0]           ofs_r, ofs_nxt;
  logic [OFS_W:0]             ofs_inc;
  logic [15:0]                crc_upd;
  logic                       store_we;
  logic                       frame_end;
  logic [7:0]                 store_r [STORE_DEPTH];
  logic [NUM_TAGS-1:0][7:0]   tag_r;
  logic [REC_BYTES-1:0][7:0]  view;
  logic                       crc_ok;

  assign crc_upd = crc_byte(crc_r, rx_byte);
  assign ofs_inc = {1'b0, ofs_r} + 1'b1;

  always_comb begin
    state_nxt = state_r;
    len_nxt   = len_r;
    rcrc_nxt  = rcrc_r;
    crc_nxt   = crc_r;
    ofs_nxt   = ofs_r;
    store_we  = 1'b0;
    frame_end = 1'b0;
    if (byte_acc) begin
      unique case (state_r)
        ST_IDLE: begin
          if (rx_byte == SYNC1_BYTE) state_nxt = ST_SYNC2;
        end
        ST_SYNC2: begin
          if (rx_byte == SYNC2_BYTE) begin
            crc_nxt   = CRC_SYNC_INIT;
            state_nxt = ST_LENL;
          end else begin
            state_nxt = ST_IDLE;
          end
        end
        ST_LENL: begin
          len_nxt   = {8'h00, rx_byte};
          crc_nxt   = crc_upd;
          state_nxt = ST_LENH;
        end
        ST_LENH: begin
          len_nxt   = {rx_byte, len_r[7:0]};
          crc_nxt   = crc_upd;
          state_nxt = ST_CRCL;
        end
        ST_CRCL: begin
          rcrc_nxt  = {8'h00, rx_byte};
          state_nxt = ST_CRCH;
        end
        ST_CRCH: begin
          rcrc_nxt  = {rx_byte, rcrc_r[7:0]};
          ofs_nxt   = '0;
          state_nxt = ST_DATA;
        end
        ST_DATA: begin
          if (ofs_r >= OFS_W'(MAX_PAYLOAD)) begin
            // Oversize payload: drop this byte and the frame.
            ofs_nxt   = '0;
            state_nxt = ST_IDLE;
          end else begin
            store_we = (ofs_r < OFS_W'(STORE_DEPTH));
            ofs_nxt  = ofs_inc[OFS_W-1:0];
            crc_nxt  = crc_upd;
            if (LEN_CMP_W'(ofs_inc) >= LEN_CMP_W'(len_r)) begin
              frame_end = 1'b1;
              state_nxt = ST_IDLE;
            end
          end
        end
        default: state_nxt = ST_IDLE;
      endcase
    end
  end

  // Store contents as they will be after this byte lands.
  always_comb begin
    for (int i = 0; i < REC_BYTES; i++) begin
      view[i] = (store_we && ofs_r == OFS_W'(i)) ? rx_byte : store_r[i];
    end
  end

  assign crc_ok = (crc_upd == rcrc_r);

  always_comb begin
    push_rec.ok    = crc_ok;
    push_rec.len   = len_r;
    push_rec.bytes = view;
    for (int k = 0; k < NUM_TAGS; k++) begin
      push_rec.mask[k] = crc_ok && (view[TAG_OFS[k]] == tag_r[k]);
    end
  end

  assign push = frame_end;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
      len_r   <= '0;
      rcrc_r  <= '0;
      crc_r   <= '0;
      ofs_r   <= '0;
      tag_r   <= TAG_RESET;
      for (int i = 0; i < STORE_DEPTH; i++) store_r[i] <= '0;
    end else begin
      state_r <= state_nxt;
      len_r   <= len_nxt;
      rcrc_r  <= rcrc_nxt;
      crc_r   <= crc_nxt;
      ofs_r   <= ofs_nxt;
      if (store_we) store_r[ofs_r[STORE_AW-1:0]] <= rx_byte;
      if (cfg_wr.valid) begin
        unique case (cfg_wr.index)
          REG_ID_TAG:     tag_r[0] <= cfg_wr.data;
          REG_ACCEL_TAG:  tag_r[1] <= cfg_wr.data;
          REG_GYRO_TAG:   tag_r[2] <= cfg_wr.data;
          REG_MAGNET_TAG: tag_r[3] <= cfg_wr.data;
          REG_EULER_TAG:  tag_r[4] <= cfg_wr.data;
          default: ;
        endcase
      end
    end
  end

endmodule

// ===== design/ifd_queue.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder record queue
// Two-entry queue of frame records between the front and back ends.
// ----------------------------------------------------------------------------
module ifd_queue (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              push,
  input  ifd_pkg::ifd_rec_t push_rec,
  output logic              full,
  input  logic              pop,
  output logic              nonempty,
  output ifd_pkg::ifd_rec_t head_rec
);
  import ifd_pkg::*;

  ifd_rec_t         mem_r [Q_DEPTH];
  logic [Q_AW-1:0]  wp_r;
  logic [Q_AW-1:0]  rp_r;
  logic [Q_AW:0]    cnt_r;
  logic             do_push;
  logic             do_pop;

  assign full     = (cnt_r == (Q_AW + 1)'(Q_DEPTH));
  assign nonempty = (cnt_r != '0);
  assign head_rec = mem_r[rp_r];
  assign do_push  = push && !full;
  assign do_pop   = pop && nonempty;

  always_ff @(posedge clk) begin
    if (do_push) mem_r[wp_r] <= push_rec;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= '0;
      rp_r  <= '0;
      cnt_r <= '0;
    end else begin
      if (do_push) wp_r <= wp_r + 1'b1;
      if (do_pop)  rp_r <= rp_r + 1'b1;
      if (do_push && !do_pop)      cnt_r <= cnt_r + 1'b1;
      else if (do_pop && !do_push) cnt_r <= cnt_r - 1'b1;
    end
  end

endmodule

// ===== design/ifd_back.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder back end
// Walks the matched items of the head record, one result per cycle unless the
// output stalls, then the status result, into a registered output stage.
// ----------------------------------------------------------------------------
module ifd_back (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              rec_valid,
  input  ifd_pkg::ifd_rec_t rec,
  output logic              rec_pop,
  output logic              out_valid,
  input  logic              out_ready,
  output logic [2:0]        out_kind,
  output logic [47:0]       out_data,
  output logic              out_last
);
  import ifd_pkg::*;

  logic                first_r;
  logic [NUM_TAGS-1:0] pend_r;
  logic [NUM_TAGS-1:0] cur_mask;
  logic [NUM_TAGS-1:0] low_bit;
  logic [2:0]          sel;
  logic                load;
  logic                out_valid_r;
  logic [2:0]          kind_r, kind_nxt;
  logic [47:0]         data_r, data_nxt;
  logic                last_r, last_nxt;

  function automatic logic [15:0] le16(input logic [REC_BYTES-1:0][7:0] b, input int idx);
    return {b[idx + 1], b[idx]};
  endfunction

  assign cur_mask = first_r ? rec.mask : pend_r;
  assign load     = rec_valid && (!out_valid_r || out_ready);

  always_comb begin
    sel     = KIND_STATUS;
    low_bit = '0;
    for (int k = NUM_TAGS - 1; k >= 0; k--) begin
      if (cur_mask[k]) begin
        sel     = 3'(k);
        low_bit = NUM_TAGS'(1) << k;
      end
    end
  end

  always_comb begin
    kind_nxt = sel;
    last_nxt = 1'b0;
    unique case (sel)
      KIND_ID:     data_nxt = {32'h0, 8'h00, rec.bytes[TAG_OFS[0] + 1]};
      KIND_ACCEL:  data_nxt = {le16(rec.bytes, TAG_OFS[1] + 5), le16(rec.bytes, TAG_OFS[1] + 3),
                               le16(rec.bytes, TAG_OFS[1] + 1)};
      KIND_GYRO:   data_nxt = {le16(rec.bytes, TAG_OFS[2] + 5), le16(rec.bytes, TAG_OFS[2] + 3),
                               le16(rec.bytes, TAG_OFS[2] + 1)};
      KIND_MAGNET: data_nxt = {le16(rec.bytes, TAG_OFS[3] + 5), le16(rec.bytes, TAG_OFS[3] + 3),
                               le16(rec.bytes, TAG_OFS[3] + 1)};
      KIND_EULER:  data_nxt = {le16(rec.bytes, TAG_OFS[4] + 5), le16(rec.bytes, TAG_OFS[4] + 3),
                               le16(rec.bytes, TAG_OFS[4] + 1)};
      default: begin
        // Status closes the frame: 0 for a good CRC, 1 for a mismatch.
        data_nxt = {16'h0000, rec.len, 15'h0000, !rec.ok};
        last_nxt = 1'b1;
      end
    endcase
  end

  assign rec_pop = load && (sel == KIND_STATUS);

  always_ff @(posedge clk) begin
    if (load) begin
      kind_r <= kind_nxt;
      data_r <= data_nxt;
      last_r <= last_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
      first_r     <= 1'b1;
      pend_r      <= '0;
    end else begin
      if (load) begin
        out_valid_r <= 1'b1;
        if (sel == KIND_STATUS) begin
          first_r <= 1'b1;
        end else begin
          first_r <= 1'b0;
          pend_r  <= cur_mask & ~low_bit;
        end
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  assign out_valid = out_valid_r;
  assign out_kind  = kind_r;
  assign out_data  = data_r;
  assign out_last  = last_r;

endmodule

// ===== design/ifd_checker.sv =====
// ----------------------------------------------------------------------------
// IMU frame decoder checker
// Port-level assertions on the result stream, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module ifd_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [47:0] out_tdata,
  input logic [2:0]  out_tuser,
  input logic        out_tlast
);
  import ifd_pkg::*;

  // The status word, and only it, closes a frame.
  `ASSERT_IMPLY(a_last_is_status, out_tvalid && out_tlast, out_tuser == KIND_STATUS, "last word is not status")
  `ASSERT_IMPLY(a_item_not_last, out_tvalid && !out_tlast, out_tuser == KIND_ID || out_tuser == KIND_ACCEL || out_tuser == KIND_GYRO || out_tuser == KIND_MAGNET || out_tuser == KIND_EULER, "item word has a bad kind")
  // Status carries only a pass/fail flag and the length.
  `ASSERT_IMPLY(a_status_fields, out_tvalid && out_tlast, out_tdata[15:1] == 15'h0000 && out_tdata[47:32] == 16'h0000, "status word has stray bits")
  // A stalled word holds.
  `ASSERT_NEXT(a_out_hold, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tuser) && $stable(out_tlast), "output changed while stalled")

endmodule

bind imu_frame_decoder ifd_checker u_ifd_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
